// ===== rtl/dkpg_pkg.sv =====
// Shared types, constants and the arctangent table of the Doppler phase estimator.
package dkpg_pkg;

  // configuration register indexes
  localparam logic [2:0] REG_ROW_LENGTH = 3'd0;
  localparam logic [2:0] REG_ROW_COUNT  = 3'd1;
  localparam logic [2:0] REG_WIN_COLS   = 3'd2;
  localparam logic [2:0] REG_WIN_ROWS   = 3'd3;
  localparam logic [2:0] REG_MIN_LEVEL  = 3'd4;
  localparam logic [2:0] REG_MAX_LEVEL  = 3'd5;

  localparam int CW           = 64;  // CORDIC vector width
  localparam int ZW           = 34;  // angle accumulator, units pi/2^31
  localparam int NORM_BIT     = 60;
  localparam int CORDIC_ITERS = 30;
  localparam int IW_CNT       = 5;

  typedef enum logic [4:0] {
    S_IDLE, S_RD, S_WT, S_M0, S_M1, S_M2, S_M3, S_M4, S_COL, S_WIN,
    S_GATE, S_CINIT, S_NORM, S_ITER, S_ROUND, S_EMIT
  } state_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_ACCEPT, OP_RD, OP_LATCH, OP_M0, OP_M1, OP_M2, OP_M3, OP_M4,
    OP_COL, OP_WIN, OP_GATE, OP_CINIT, OP_NORM, OP_ITER, OP_ROUND, OP_EMIT
  } op_t;

  typedef struct packed {
    op_t op;
  } ctrl_t;

  typedef struct packed {
    logic win_ok;
    logic first_pair;
    logic last_pair;
    logic emit_ok;
    logic gate_hit;
    logic zero_vec;
    logic norm_done;
    logic iter_done;
    logic out_free;
  } stat_t;

  function automatic logic [29:0] atan_val(input logic [IW_CNT-1:0] i);
    logic [29:0] v;
    case (i)
      5'd0:  v = 30'd536870912;
      5'd1:  v = 30'd316933406;
      5'd2:  v = 30'd167458907;
      5'd3:  v = 30'd85004756;
      5'd4:  v = 30'd42667331;
      5'd5:  v = 30'd21354465;
      5'd6:  v = 30'd10679838;
      5'd7:  v = 30'd5340245;
      5'd8:  v = 30'd2670163;
      5'd9:  v = 30'd1335087;
      5'd10: v = 30'd667544;
      5'd11: v = 30'd333772;
      5'd12: v = 30'd166886;
      5'd13: v = 30'd83443;
      5'd14: v = 30'd41721;
      5'd15: v = 30'd20860;
      5'd16: v = 30'd10430;
      5'd17: v = 30'd5215;
      5'd18: v = 30'd2607;
      5'd19: v = 30'd1303;
      5'd20: v = 30'd651;
      5'd21: v = 30'd325;
      5'd22: v = 30'd162;
      5'd23: v = 30'd81;
      5'd24: v = 30'd40;
      5'd25: v = 30'd20;
      5'd26: v = 30'd10;
      5'd27: v = 30'd5;
      5'd28: v = 30'd2;
      5'd29: v = 30'd1;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/dkpg_ctrl.sv =====
// Sequencer for the estimator: steps one beat through accumulate, window and CORDIC.
module dkpg_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  dkpg_pkg::stat_t stat,
  output dkpg_pkg::ctrl_t cmd
);

  dkpg_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= dkpg_pkg::S_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    cmd.op     = dkpg_pkg::OP_NONE;
    in_ready   = 1'b0;
    unique case (state)
      dkpg_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op = dkpg_pkg::OP_ACCEPT;
          if (stat.win_ok) state_next = dkpg_pkg::S_RD;
        end
      end
      dkpg_pkg::S_RD: begin
        cmd.op     = dkpg_pkg::OP_RD;
        state_next = dkpg_pkg::S_WT;
      end
      dkpg_pkg::S_WT: begin
        cmd.op     = dkpg_pkg::OP_LATCH;
        state_next = stat.first_pair ? dkpg_pkg::S_RD : dkpg_pkg::S_M0;
      end
      dkpg_pkg::S_M0: begin
        cmd.op = dkpg_pkg::OP_M0; state_next = dkpg_pkg::S_M1;
      end
      dkpg_pkg::S_M1: begin
        cmd.op = dkpg_pkg::OP_M1; state_next = dkpg_pkg::S_M2;
      end
      dkpg_pkg::S_M2: begin
        cmd.op = dkpg_pkg::OP_M2; state_next = dkpg_pkg::S_M3;
      end
      dkpg_pkg::S_M3: begin
        cmd.op = dkpg_pkg::OP_M3; state_next = dkpg_pkg::S_M4;
      end
      dkpg_pkg::S_M4: begin
        cmd.op     = dkpg_pkg::OP_M4;
        state_next = stat.last_pair ? dkpg_pkg::S_COL : dkpg_pkg::S_RD;
      end
      dkpg_pkg::S_COL: begin
        cmd.op = dkpg_pkg::OP_COL; state_next = dkpg_pkg::S_WIN;
      end
      dkpg_pkg::S_WIN: begin
        cmd.op     = dkpg_pkg::OP_WIN;
        state_next = stat.emit_ok ? dkpg_pkg::S_GATE : dkpg_pkg::S_IDLE;
      end
      dkpg_pkg::S_GATE: begin
        cmd.op     = dkpg_pkg::OP_GATE;
        state_next = stat.gate_hit ? dkpg_pkg::S_EMIT : dkpg_pkg::S_CINIT;
      end
      dkpg_pkg::S_CINIT: begin
        cmd.op     = dkpg_pkg::OP_CINIT;
        state_next = stat.zero_vec ? dkpg_pkg::S_EMIT : dkpg_pkg::S_NORM;
      end
      dkpg_pkg::S_NORM: begin
        cmd.op = dkpg_pkg::OP_NORM;
        if (stat.norm_done) state_next = dkpg_pkg::S_ITER;
      end
      dkpg_pkg::S_ITER: begin
        cmd.op = dkpg_pkg::OP_ITER;
        if (stat.iter_done) state_next = dkpg_pkg::S_ROUND;
      end
      dkpg_pkg::S_ROUND: begin
        cmd.op = dkpg_pkg::OP_ROUND; state_next = dkpg_pkg::S_EMIT;
      end
      dkpg_pkg::S_EMIT: begin
        if (stat.out_free) begin
          cmd.op     = dkpg_pkg::OP_EMIT;
          state_next = dkpg_pkg::S_IDLE;
        end
      end
      default: state_next = dkpg_pkg::S_IDLE;
    endcase
  end

endmodule

// ===== rtl/dkpg_datapath.sv =====
// Datapath: line store, column store, pair accumulator, window sums, gate and CORDIC.
module dkpg_datapath #(
  parameter int MAX_ROW_LEN  = 1024,
  parameter int MAX_WIN_COLS = 16,
  parameter int MAX_WIN_ROWS = 8,
  parameter int SAMPLE_BITS  = 16,
  parameter int PHASE_BITS   = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  dkpg_pkg::ctrl_t               cmd,
  output dkpg_pkg::stat_t               stat,
  input  logic                          cfg_we,
  input  logic [2:0]                    cfg_addr,
  input  logic [15:0]                   cfg_wdata,
  input  logic signed [SAMPLE_BITS-1:0] re,
  input  logic signed [SAMPLE_BITS-1:0] im,
  input  logic [15:0]                   intensity,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic signed [PHASE_BITS-1:0]  phase,
  output logic [9:0]                    window_col,
  output logic [15:0]                   window_row,
  output logic                          gated
);

  localparam int NSLOTS = MAX_WIN_ROWS + 1;
  localparam int SLW    = $clog2(NSLOTS);
  localparam int CB     = $clog2(MAX_ROW_LEN);
  localparam int RLW    = $clog2(MAX_ROW_LEN + 1);
  localparam int XW     = $clog2(MAX_WIN_COLS + 1);
  localparam int YW     = $clog2(MAX_WIN_ROWS + 1);
  localparam int SB     = SAMPLE_BITS;
  localparam int MW     = 2 * SB + 16;
  localparam int PRW    = 2 * SB;
  localparam int ACW    = 2 * SB + 2 + XW + YW;
  localparam int ICW    = 16 + YW;
  localparam int IW     = 16 + XW + YW;
  localparam int AW     = XW + YW;
  localparam int CW     = dkpg_pkg::CW;
  localparam int ZW     = dkpg_pkg::ZW;
  localparam logic signed [CW-1:0] NORM_LIMIT = CW'(1) << dkpg_pkg::NORM_BIT;
  localparam logic signed [ZW-1:0] Z_PI       = ZW'(1) << 31;
  localparam logic signed [ZW-1:0] Z_RND      = ZW'(1) << (31 - PHASE_BITS);
  localparam logic signed [ZW-1:0] PH_HI      = (ZW'(1) << (PHASE_BITS - 1)) - ZW'(1);
  localparam logic signed [ZW-1:0] PH_LO      = -PH_HI - ZW'(1);

  // configuration
  logic [10:0] row_length;
  logic [15:0] row_count;
  logic [4:0]  win_cols;
  logic [3:0]  win_rows;
  logic [15:0] min_level, max_level;
  logic [RLW-1:0] rl;
  logic [XW-1:0]  xd;
  logic [YW-1:0]  yd;
  logic [AW-1:0]  area;

  // position
  logic [CB-1:0]  col_pos, c_now, c_w;
  logic [15:0]    row_pos, r_w;
  logic [SLW-1:0] slot_pos, start_slot, rd_slot;
  logic [YW:0]    k;

  // stores
  logic [MW-1:0]          smem [NSLOTS][MAX_ROW_LEN];
  logic [2*ACW+ICW-1:0]   cmem [MAX_ROW_LEN];
  logic [MW-1:0]          rdata, cur, prev;
  logic [2*ACW+ICW-1:0]   col_rd;

  // accumulation
  logic signed [PRW-1:0] prod;
  logic signed [ACW-1:0] cs, ds, cwin, dwin;
  logic [ICW-1:0]        isum;
  logic [IW-1:0]         iwin, thr_hi, thr_lo;
  logic                  sub_old;

  // CORDIC
  logic signed [CW-1:0] x, y, ax, ay, xs, ys, x0, y0;
  logic signed [ZW-1:0] z, zr, rr;
  logic [dkpg_pkg::IW_CNT-1:0] ie;

  // result
  logic signed [PHASE_BITS-1:0] ph_r;
  logic                         gated_r;
  logic [9:0]                   o_col;
  logic [15:0]                  o_row;

  logic signed [SB-1:0] re_a, im_a, re_b, im_b;
  assign re_a = prev[SB-1:0];
  assign im_a = prev[2*SB-1:SB];
  assign re_b = cur[SB-1:0];
  assign im_b = cur[2*SB-1:SB];

  always_comb begin
    if (row_length < 11'd2)                 rl = RLW'(2);
    else if (int'(row_length) > MAX_ROW_LEN) rl = RLW'(MAX_ROW_LEN);
    else                                     rl = RLW'(row_length);
    if (win_cols == 5'd0)                    xd = XW'(1);
    else if (int'(win_cols) > MAX_WIN_COLS)  xd = XW'(MAX_WIN_COLS);
    else                                     xd = XW'(win_cols);
    if (win_rows == 4'd0)                    yd = YW'(1);
    else if (int'(win_rows) > MAX_WIN_ROWS)  yd = YW'(MAX_WIN_ROWS);
    else                                     yd = YW'(win_rows);
  end

  always_comb begin
    int ss;
    ss = int'(slot_pos) + NSLOTS - int'(yd);
    if (ss >= NSLOTS) ss = ss - NSLOTS;
    start_slot = SLW'(ss);
    c_now = (RLW'(col_pos) >= rl) ? '0 : col_pos;
  end

  assign sub_old = int'(c_w) >= int'(xd);
  assign x0 = CW'(dwin);
  assign y0 = CW'(cwin);
  assign ax = (x < 0) ? -x : x;
  assign ay = (y < 0) ? -y : y;
  assign xs = x >>> ie;
  assign ys = y >>> ie;
  assign zr = z + Z_RND;
  assign rr = zr >>> (32 - PHASE_BITS);

  always_comb begin
    stat.win_ok     = row_pos >= 16'(yd);
    stat.first_pair = k == (YW+1)'(1);
    stat.last_pair  = k == (YW+1)'(yd) + (YW+1)'(1);
    stat.emit_ok    = (int'(r_w) + 1 < int'(row_count)) && (int'(c_w) + 1 >= int'(xd))
                      && (int'(c_w) + 2 <= int'(rl));
    stat.gate_hit   = (iwin > thr_hi) || (iwin < thr_lo);
    stat.zero_vec   = (cwin == '0) && (dwin == '0);
    stat.norm_done  = (ax >= NORM_LIMIT) || (ay >= NORM_LIMIT);
    stat.iter_done  = ie == dkpg_pkg::IW_CNT'(dkpg_pkg::CORDIC_ITERS - 1);
    stat.out_free   = !out_valid || out_ready;
  end

  // configuration and position
  always_ff @(posedge clk) begin
    if (rst) begin
      row_length <= 11'd1024;
      row_count  <= 16'd512;
      win_cols   <= 5'd4;
      win_rows   <= 4'd4;
      min_level  <= 16'd0;
      max_level  <= 16'hFFFF;
      col_pos    <= '0;
      row_pos    <= '0;
      slot_pos   <= '0;
    end else if (cfg_we && cfg_addr <= dkpg_pkg::REG_MAX_LEVEL) begin
      unique case (cfg_addr)
        dkpg_pkg::REG_ROW_LENGTH: row_length <= cfg_wdata[10:0];
        dkpg_pkg::REG_ROW_COUNT:  row_count  <= cfg_wdata;
        dkpg_pkg::REG_WIN_COLS:   win_cols   <= cfg_wdata[4:0];
        dkpg_pkg::REG_WIN_ROWS:   win_rows   <= cfg_wdata[3:0];
        dkpg_pkg::REG_MIN_LEVEL:  min_level  <= cfg_wdata;
        dkpg_pkg::REG_MAX_LEVEL:  max_level  <= cfg_wdata;
        default: ;
      endcase
      col_pos  <= '0;
      row_pos  <= '0;
      slot_pos <= '0;
    end else if (cmd.op == dkpg_pkg::OP_ACCEPT) begin
      if (RLW'(c_now) + RLW'(1) >= rl) begin
        col_pos <= '0;
        if (17'(row_pos) + 17'd1 >= 17'(row_count)) begin
          row_pos  <= '0;
          slot_pos <= '0;
        end else begin
          row_pos  <= row_pos + 16'd1;
          slot_pos <= (slot_pos == SLW'(NSLOTS - 1)) ? '0 : slot_pos + SLW'(1);
        end
      end else begin
        col_pos <= c_now + CB'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) area <= '0;
    else     area <= AW'(xd) * AW'(yd);
  end

  // line store
  always_ff @(posedge clk) begin
    if (cmd.op == dkpg_pkg::OP_ACCEPT)
      smem[slot_pos][c_now] <= {intensity, im, re};
    if (cmd.op == dkpg_pkg::OP_RD)
      rdata <= smem[rd_slot][c_w];
  end

  // column store
  always_ff @(posedge clk) begin
    if (cmd.op == dkpg_pkg::OP_COL) begin
      cmem[c_w] <= {isum, ds, cs};
      col_rd    <= cmem[c_w - CB'(xd)];
    end
  end

  // pair accumulation, window and CORDIC
  always_ff @(posedge clk) begin
    case (cmd.op)
      dkpg_pkg::OP_ACCEPT: begin
        c_w     <= c_now;
        r_w     <= row_pos;
        rd_slot <= start_slot;
        k       <= '0;
        cs      <= '0;
        ds      <= '0;
        isum    <= '0;
      end
      dkpg_pkg::OP_RD: begin
        rd_slot <= (rd_slot == SLW'(NSLOTS - 1)) ? '0 : rd_slot + SLW'(1);
        k       <= k + (YW+1)'(1);
      end
      dkpg_pkg::OP_LATCH: begin
        cur  <= rdata;
        prev <= cur;
      end
      dkpg_pkg::OP_M0: prod <= im_a * re_b;
      dkpg_pkg::OP_M1: begin
        cs   <= cs + ACW'(prod);
        prod <= re_a * im_b;
      end
      dkpg_pkg::OP_M2: begin
        cs   <= cs - ACW'(prod);
        prod <= im_a * im_b;
      end
      dkpg_pkg::OP_M3: begin
        ds   <= ds + ACW'(prod);
        prod <= re_a * re_b;
      end
      dkpg_pkg::OP_M4: begin
        ds   <= ds + ACW'(prod);
        isum <= isum + ICW'(prev[MW-1:2*SB]);
      end
      dkpg_pkg::OP_COL: begin
        thr_hi <= IW'(max_level * area);
        thr_lo <= IW'(min_level * area);
      end
      dkpg_pkg::OP_WIN: begin
        cwin  <= ((c_w == '0) ? '0 : cwin) + cs
                 - (sub_old ? $signed(col_rd[ACW-1:0]) : '0);
        dwin  <= ((c_w == '0) ? '0 : dwin) + ds
                 - (sub_old ? $signed(col_rd[2*ACW-1:ACW]) : '0);
        iwin  <= ((c_w == '0) ? '0 : iwin) + IW'(isum)
                 - (sub_old ? IW'(col_rd[2*ACW+ICW-1:2*ACW]) : '0);
        o_col <= 10'(int'(c_w) + 1 - int'(xd));
        o_row <= r_w - 16'(yd);
      end
      dkpg_pkg::OP_GATE: begin
        gated_r <= stat.gate_hit;
        ph_r    <= '0;
      end
      dkpg_pkg::OP_CINIT: begin
        ie <= '0;
        if (x0 < 0) begin
          x <= -x0;
          y <= -y0;
          z <= (y0 >= 0) ? Z_PI : -Z_PI;
        end else begin
          x <= x0;
          y <= y0;
          z <= '0;
        end
      end
      dkpg_pkg::OP_NORM: begin
        if (!stat.norm_done) begin
          x <= x <<< 1;
          y <= y <<< 1;
        end
      end
      dkpg_pkg::OP_ITER: begin
        ie <= ie + dkpg_pkg::IW_CNT'(1);
        if (y >= 0) begin
          x <= x + ys;
          y <= y - xs;
          z <= z + ZW'(dkpg_pkg::atan_val(ie));
        end else begin
          x <= x - ys;
          y <= y + xs;
          z <= z - ZW'(dkpg_pkg::atan_val(ie));
        end
      end
      dkpg_pkg::OP_ROUND: begin
        if (rr > PH_HI)      ph_r <= PHASE_BITS'(PH_HI);
        else if (rr < PH_LO) ph_r <= PHASE_BITS'(PH_LO);
        else                 ph_r <= PHASE_BITS'(rr);
      end
      default: ;
    endcase
  end

  // a gated result or a zero vector leaves the phase at 0
  always_ff @(posedge clk) begin
    if (cmd.op == dkpg_pkg::OP_EMIT) begin
      phase      <= (gated_r || stat.zero_vec) ? '0 : ph_r;
      window_col <= o_col;
      window_row <= o_row;
      gated      <= gated_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rst)                             out_valid <= 1'b0;
    else if (cmd.op == dkpg_pkg::OP_EMIT) out_valid <= 1'b1;
    else if (out_ready)                  out_valid <= 1'b0;
  end

endmodule

// ===== rtl/doppler_kasai_phase_gated.sv =====
// A beat that completes no column pair is only stored; otherwise the row pairs are read and
// multiplied, the column and window sums follow, then a gated result or a zero vector skips
// the CORDIC, and any other vector is normalised by doublings before the CORDIC iterations.
// Input: one beat at a time; the shared multiplier (four products per row pair)
// and the bit-per-cycle CORDIC hold the next beat off. The result register frees the input side.
// Reset: synchronous, clears the sequencer, position and registers to 1024/512/4/4/0/65535.
module doppler_kasai_phase_gated #(
  parameter int MAX_ROW_LEN  = 1024,
  parameter int MAX_WIN_COLS = 16,
  parameter int MAX_WIN_ROWS = 8,
  parameter int SAMPLE_BITS  = 16,
  parameter int PHASE_BITS   = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [2:0]                    cfg_addr,
  input  logic [15:0]                   cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [SAMPLE_BITS-1:0] re,
  input  logic signed [SAMPLE_BITS-1:0] im,
  input  logic [15:0]                   intensity,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [PHASE_BITS-1:0]  phase,
  output logic [9:0]                    window_col,
  output logic [15:0]                   window_row,
  output logic                          gated
);

  dkpg_pkg::ctrl_t cmd;
  dkpg_pkg::stat_t stat;

  dkpg_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  dkpg_datapath #(
    .MAX_ROW_LEN  (MAX_ROW_LEN),
    .MAX_WIN_COLS (MAX_WIN_COLS),
    .MAX_WIN_ROWS (MAX_WIN_ROWS),
    .SAMPLE_BITS  (SAMPLE_BITS),
    .PHASE_BITS   (PHASE_BITS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .re         (re),
    .im         (im),
    .intensity  (intensity),
    .out_ready  (out_ready),
    .out_valid  (out_valid),
    .phase      (phase),
    .window_col (window_col),
    .window_row (window_row),
    .gated      (gated)
  );

endmodule
